[rtl/kpl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared sizes, operation codes and table entry type for the key lookup block.
// ----------------------------------------------------------------------------
package kpl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int POS_W       = 11;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[rtl/key_to_position_lookup_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// key_to_position_lookup_top
// Sorted key table with binary search lookup of 1-based load positions.
// ----------------------------------------------------------------------------
// One item at a time; in_ready is high only while idle. A clear is handled in
// the idle state. A query runs a binary search over the sorted table, each
// probe a RAM read, then a compare. A load runs the same binary search, but
// for the upper bound, then moves every entry above the insert point up by
// one, one entry per cycle through the single RAM read and write port, then
// writes the new key. The result of a query sits in an output register, so
// the next item is taken while it waits. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module key_to_position_lookup_top
    import kpl_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         operation,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic                    last_query,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [POS_W-1:0]             position,
    output logic                         found,
    output logic                         overflow,
    output logic                         last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_QCHK  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_INS   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             is_load_reg, is_load_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             wpend_reg, wpend_next;
    logic [IDX_W-1:0] waddr_reg, waddr_next;
    logic             out_valid_reg, out_valid_next;

    logic signed [KEY_W-1:0] key_reg;
    logic                    lastq_reg;
    logic [POS_W-1:0]        res_pos_reg, res_pos_next;
    logic                    res_found_reg, res_found_next;
    logic [POS_W-1:0]        position_reg;
    logic                    found_reg;
    logic                    overflow_reg;
    logic                    last_reg;

    logic             in_fire;
    logic             out_load;
    logic [CNT_W:0]   mid_sum;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rbits;
    entry_t           rd_entry;
    logic             go_right;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign found     = found_reg;
    assign overflow  = overflow_reg;
    assign last      = last_reg;
    assign rd_entry  = entry_t'(ram_rbits);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};

    // upper bound for loads, lower bound for queries
    assign go_right = is_load_reg ? (rd_entry.key <= key_reg) : (rd_entry.key < key_reg);

    kpl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rbits)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        is_load_next   = is_load_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ptr_next       = ptr_reg;
        wpend_next     = 1'b0;
        waddr_next     = waddr_reg;
        res_pos_next   = res_pos_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = waddr_reg;
        ram_wdata      = rd_entry;
        ram_raddr      = mid_sum[IDX_W:1];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    lo_next      = '0;
                    hi_next      = count_reg;
                    is_load_next = (operation == OP_LOAD);
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        OP_LOAD:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        OP_QUERY:
                        begin
                            state_next = S_SRCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[IDX_W:1];
                    state_next = S_WAIT;
                end
                else if (is_load_reg)
                begin
                    ptr_next   = count_reg[IDX_W-1:0];
                    state_next = S_SHIFT;
                end
                else if (lo_reg < count_reg)
                begin
                    ram_raddr  = lo_reg[IDX_W-1:0];
                    state_next = S_QCHK;
                end
                else
                begin
                    res_pos_next   = '0;
                    res_found_next = 1'b0;
                    state_next     = S_RESP;
                end
            end
            S_WAIT:
            begin
                if (go_right)
                begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end
                else
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                state_next = S_SRCH;
            end
            S_QCHK:
            begin
                res_found_next = (rd_entry.key == key_reg);
                res_pos_next   = (rd_entry.key == key_reg) ? rd_entry.pos : '0;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // read ptr-1 now, write it to ptr on the next cycle
                ram_we    = wpend_reg;
                ram_raddr = ptr_reg - IDX_W'(1);
                if (CNT_W'(ptr_reg) > lo_reg)
                begin
                    wpend_next = 1'b1;
                    waddr_next = ptr_reg;
                    ptr_next   = ptr_reg - IDX_W'(1);
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                ram_we        = 1'b1;
                ram_waddr     = lo_reg[IDX_W-1:0];
                ram_wdata.key = key_reg;
                ram_wdata.pos = POS_W'(count_reg + CNT_W'(1));
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            is_load_reg   <= 1'b0;
            wpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            is_load_reg   <= is_load_next;
            wpend_reg     <= wpend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        ptr_reg       <= ptr_next;
        waddr_reg     <= waddr_next;
        res_pos_reg   <= res_pos_next;
        res_found_reg <= res_found_next;
        if (in_fire)
        begin
            key_reg   <= key;
            lastq_reg <= last_query;
        end
        if (out_load)
        begin
            position_reg <= res_pos_reg;
            found_reg    <= res_found_reg;
            overflow_reg <= ovf_reg;
            last_reg     <= lastq_reg;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (position_reg != '0))
        else $error("hit with zero position");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (position_reg == '0))
        else $error("miss with non-zero position");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance entry count");
`endif

endmodule
`default_nettype wire

[rtl/kpl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kpl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kpl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[verif/key_to_position_lookup_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_to_position_lookup_top_tb
// Self-checking bench for the sorted key table lookup.
// A short directed table covers the extremes, duplicates, clears, empty-table
// and unused-opcode cases. One full fill exercises capacity and dropped
// loads. Random load/query batches under four idling mixes follow. Query
// results are checked field by field against a load-order model of the
// table, or against the typed-in expectation of a directed row.
// ----------------------------------------------------------------------------
module key_to_position_lookup_top_tb;
    import kpl_pkg::*;

    localparam logic [OP_W-1:0]         OP_UNUSED   = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN     = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX     = {1'b0, {(KEY_W-1){1'b1}}};
    localparam int                      RAND_ITEMS  = 256;
    localparam int                      SETTLE_CYC  = 1200;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
        logic             overflow;
        logic             last;
    } lookup_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic                    last_query;
        logic                    typed;
        lookup_t                 want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key;
    logic                    last_query;
    logic                    out_valid;
    logic                    out_ready;
    logic [POS_W-1:0]        position;
    logic                    found;
    logic                    overflow;
    logic                    last;

    // typed-in expectation travelling with the current directed item
    logic    row_typed;
    lookup_t row_expect;

    // model of the table, kept in load order
    logic signed [KEY_W-1:0] model_keys [TABLE_DEPTH];
    int                      model_count;
    bit                      model_overflow;

    lookup_t                 expected_lookups [$];
    logic signed [KEY_W-1:0] stim_keys [$];

    int send_idle_pct;
    int stall_pct;
    int errors;
    int items_driven;
    int random_items;
    int lookups_checked;
    int lookup_hits;
    int dropped_loads;

    stim_row_t directed_rows [21] = '{
        '{OP_QUERY,  32'sd0,  1'b1, 1'b1, '{11'd0, 1'b0, 1'b0, 1'b1}},
        '{OP_UNUSED, 32'sd5,  1'b0, 1'b0, '0},
        '{OP_LOAD,   KEY_MIN, 1'b0, 1'b0, '0},
        '{OP_LOAD,   KEY_MAX, 1'b1, 1'b0, '0},
        '{OP_LOAD,   32'sd0,  1'b0, 1'b0, '0},
        '{OP_LOAD,   -32'sd1, 1'b0, 1'b0, '0},
        '{OP_LOAD,   32'sd7,  1'b0, 1'b0, '0},
        '{OP_LOAD,   32'sd7,  1'b0, 1'b0, '0},
        '{OP_QUERY,  KEY_MIN, 1'b0, 1'b1, '{11'd1, 1'b1, 1'b0, 1'b0}},
        '{OP_QUERY,  KEY_MAX, 1'b0, 1'b1, '{11'd2, 1'b1, 1'b0, 1'b0}},
        '{OP_QUERY,  32'sd0,  1'b0, 1'b1, '{11'd3, 1'b1, 1'b0, 1'b0}},
        '{OP_QUERY,  -32'sd1, 1'b0, 1'b1, '{11'd4, 1'b1, 1'b0, 1'b0}},
        '{OP_QUERY,  32'sd7,  1'b0, 1'b1, '{11'd5, 1'b1, 1'b0, 1'b0}},
        '{OP_QUERY,  32'sd6,  1'b0, 1'b1, '{11'd0, 1'b0, 1'b0, 1'b0}},
        '{OP_QUERY,  32'sd8,  1'b0, 1'b1, '{11'd0, 1'b0, 1'b0, 1'b0}},
        '{OP_UNUSED, 32'sd7,  1'b1, 1'b0, '0},
        '{OP_QUERY,  -32'sd2, 1'b1, 1'b1, '{11'd0, 1'b0, 1'b0, 1'b1}},
        '{OP_CLEAR,  32'sd7,  1'b0, 1'b0, '0},
        '{OP_QUERY,  32'sd7,  1'b0, 1'b1, '{11'd0, 1'b0, 1'b0, 1'b0}},
        '{OP_LOAD,   32'sd7,  1'b0, 1'b0, '0},
        '{OP_QUERY,  32'sd7,  1'b1, 1'b1, '{11'd1, 1'b1, 1'b0, 1'b1}}
    };

    key_to_position_lookup_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key        (key),
        .last_query (last_query),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .found      (found),
        .overflow   (overflow),
        .last       (last)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // equal keys sit in load order, so the first match is the lowest position
    function automatic void step_lookup_model(input logic [OP_W-1:0] op,
                                              input logic signed [KEY_W-1:0] k,
                                              input logic lq,
                                              output bit gives,
                                              output lookup_t res);
        int hit_at;
        gives  = 1'b0;
        res    = '0;
        hit_at = -1;
        case (op)
            OP_CLEAR:
            begin
                model_count    = 0;
                model_overflow = 1'b0;
            end
            OP_LOAD:
            begin
                if (model_count >= TABLE_DEPTH)
                begin
                    model_overflow = 1'b1;
                end
                else
                begin
                    model_keys[model_count] = k;
                    model_count++;
                end
            end
            OP_QUERY:
            begin
                for (int i = 0; i < model_count && hit_at < 0; i++)
                begin
                    if (model_keys[i] == k)
                        hit_at = i;
                end
                res.position = (hit_at < 0) ? '0 : POS_W'(hit_at + 1);
                res.found    = (hit_at >= 0);
                res.overflow = model_overflow;
                res.last     = lq;
                gives        = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t want;
        bit      gives;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{position, found, overflow, last};
                lookups_checked++;
                if (got.found === 1'b1)
                    lookup_hits++;
                if (expected_lookups.size() == 0)
                begin
                    $error("unexpected result: position %0d found %0b", got.position, got.found);
                    errors++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, got.position);
                        errors++;
                    end
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, got.found);
                        errors++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (operation == OP_LOAD && model_count >= TABLE_DEPTH)
                    dropped_loads++;
                step_lookup_model(operation, key, last_query, gives, want);
                if (row_typed)
                    want = row_expect;
                if (gives)
                    expected_lookups.push_back(want);
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] k,
                             input logic lq, input logic typed, input lookup_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        key        <= k;
        last_query <= lq;
        row_typed  <= typed;
        row_expect <= want;
        do
            @(posedge clk);
        while (!in_ready);
        items_driven++;
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] k,
                         input logic lq);
        send_item(op, k, lq, 1'b0, '0);
        if (op == OP_CLEAR)
            stim_keys.delete();
        else if (op == OP_LOAD)
            stim_keys.push_back(k);
        if (op != OP_UNUSED)
            random_items++;
    endtask

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return KEY_W'($urandom_range(20));
            3:       return KEY_W'(-int'($urandom_range(1, 20)));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [KEY_W-1:0] query_key();
        logic signed [KEY_W-1:0] k;
        if (stim_keys.size() == 0 || $urandom_range(9) < 3)
            return rand_key();
        k = stim_keys[$urandom_range(stim_keys.size() - 1)];
        case ($urandom_range(5))
            0:       return k + 1;
            1:       return k - 1;
            default: return k;
        endcase
    endfunction

    // full table with non-decreasing keys, so loads append without shifting
    task automatic fill_table();
        logic signed [KEY_W-1:0] k;
        issue(OP_CLEAR, $urandom, 1'($urandom_range(1)));
        k = KEY_MIN;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            issue(OP_LOAD, (i == TABLE_DEPTH - 1) ? KEY_MAX : k, 1'($urandom_range(1)));
            k = k + KEY_W'($urandom_range(3));
        end
        for (int i = 0; i < 3; i++)
            issue(OP_LOAD, rand_key(), 1'($urandom_range(1)));
        issue(OP_QUERY, stim_keys[0], 1'b0);
        issue(OP_QUERY, stim_keys[TABLE_DEPTH - 1], 1'b0);
        for (int i = 0; i < 40; i++)
            issue(OP_QUERY, query_key(), (i == 39));
        issue(OP_CLEAR, $urandom, 1'b0);
        issue(OP_QUERY, KEY_MAX, 1'b1);
    endtask

    task automatic random_batch();
        int n_load;
        int n_query;
        if (stim_keys.size() > 150 || $urandom_range(99) < 60)
            issue(OP_CLEAR, $urandom, 1'($urandom_range(1)));
        n_load = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(12);
        for (int i = 0; i < n_load; i++)
        begin
            if (stim_keys.size() > 0 && $urandom_range(4) == 0)
                issue(OP_LOAD, stim_keys[$urandom_range(stim_keys.size() - 1)],
                      1'($urandom_range(1)));
            else
                issue(OP_LOAD, rand_key(), 1'($urandom_range(1)));
            if ($urandom_range(99) < 8)
                issue(OP_W'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
        end
        n_query = $urandom_range(1, 10);
        for (int i = 0; i < n_query; i++)
            issue(OP_QUERY, query_key(), (i == n_query - 1) || ($urandom_range(9) == 0));
    endtask

    initial
    begin
        int send_mix [4];
        int recv_mix [4];
        send_mix        = '{0, 86, 0, 15};
        recv_mix        = '{0, 0, 86, 15};
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        operation       = OP_CLEAR;
        key             = '0;
        last_query      = 1'b0;
        out_ready       = 1'b0;
        row_typed       = 1'b0;
        row_expect      = '0;
        model_count     = 0;
        model_overflow  = 1'b0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        errors          = 0;
        items_driven    = 0;
        random_items    = 0;
        lookups_checked = 0;
        lookup_hits     = 0;
        dropped_loads   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].last_query,
                      directed_rows[i].typed, directed_rows[i].want);

        fill_table();

        random_items = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_mix[ph];
            stall_pct     = recv_mix[ph];
            while (random_items < RAND_ITEMS * (ph + 1) / 4)
                random_batch();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("%0d items driven, %0d lookups checked (%0d hits, %0d misses)",
                 items_driven, lookups_checked, lookup_hits, lookups_checked - lookup_hits);
        $display("one full-table fill with %0d dropped loads; idle mixes none/send/recv/both",
                 dropped_loads);
        if (errors == 0)
            $display("key_to_position_lookup_top: match");
        else
            $display("key_to_position_lookup_top: mismatch");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("key_to_position_lookup_top: mismatch");
        $finish;
    end

endmodule
